@@ src/spd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

  localparam int COORD_BITS      = 24;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int THRESH_BITS     = 40;
  localparam int DIST_BITS       = 52;
  localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
  localparam int OFS_BITS        = COORD_BITS + 1;
  localparam int DOT_BITS        = 2 * COORD_BITS + 3;
  localparam int WIDE_BITS       = 2 * DOT_BITS + 1;
  localparam int DIV_LAT         = PARAM_FRAC_BITS + 2;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 40'd281474977;
  localparam logic [PARAM_BITS-1:0]  PARAM_ONE    = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OFS_BITS-1:0]   offset_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [PARAM_BITS-1:0]        param_t;

  typedef struct packed {
    coord_t first_origin_x;
    coord_t first_origin_y;
    coord_t first_origin_z;
    coord_t first_dir_x;
    coord_t first_dir_y;
    coord_t first_dir_z;
    coord_t second_origin_x;
    coord_t second_origin_y;
    coord_t second_origin_z;
    coord_t second_dir_x;
    coord_t second_dir_y;
    coord_t second_dir_z;
  } pair_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance_squared;
    param_t               first_param;
    param_t               second_param;
    logic                 parallel_flag;
  } result_t;

  typedef struct packed {
    coord_t  [2:0] u;
    coord_t  [2:0] v;
    offset_t [2:0] w;
  } geo_t;

endpackage
`default_nettype wire

@@ src/spd_wmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spd_wmul #(
  parameter int W = 51
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  logic signed [HI-1:0]    ah;
  logic signed [HI-1:0]    bh;
  logic [LO-1:0]           al;
  logic [LO-1:0]           bl;
  logic signed [2*HI-1:0]  hh;
  logic signed [HI+LO:0]   hl;
  logic signed [HI+LO:0]   lh;
  logic [2*LO-1:0]         ll;
  logic [2*W-1:0]          hh_x;
  logic [2*W-1:0]          mid_x;
  logic [2*W-1:0]          ll_x;

  assign ah = $signed(a[W-1:LO]);
  assign bh = $signed(b[W-1:LO]);
  assign al = a[LO-1:0];
  assign bl = b[LO-1:0];

  always_ff @(posedge clk) begin
    hh <= ah * bh;
    hl <= ah * $signed({1'b0, bl});
    lh <= $signed({1'b0, al}) * bh;
    ll <= al * bl;
  end

  always_comb begin
    hh_x  = {{(2*W-2*HI){hh[2*HI-1]}}, hh};
    mid_x = {{(2*W-HI-LO-1){hl[HI+LO]}}, hl} + {{(2*W-HI-LO-1){lh[HI+LO]}}, lh};
    ll_x  = {{(2*W-2*LO){1'b0}}, ll};
  end

  always_ff @(posedge clk) begin
    p <= $signed((hh_x << (2*LO)) + (mid_x << LO) + ll_x);
  end

endmodule
`default_nettype wire

@@ src/spd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spd_div #(
  parameter int W  = 103,
  parameter int QB = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic [QB:0]         quo
);

  logic [W-1:0]  rem_q  [QB+1];
  logic [W-1:0]  den_q  [QB+1];
  logic [QB-1:0] q_q    [QB+1];
  logic          zero_q [QB+1];
  logic          one_q  [QB+1];
  logic [W:0]    step   [QB+1];
  logic          num_pos;
  logic          den_pos;

  function automatic logic [W:0] div_step(input logic [W-1:0] r, input logic [W-1:0] dv);
    logic [W:0] r2;
    logic [W:0] dx;
    r2 = {r, 1'b0};
    dx = {1'b0, dv};
    if (r2 >= dx) begin
      return {1'b1, W'(r2 - dx)};
    end
    return {1'b0, r2[W-1:0]};
  endfunction

  assign num_pos = !num[W-1] && (|num);
  assign den_pos = !den[W-1] && (|den);

  always_comb begin
    step[0] = '0;
    for (int j = 1; j <= QB; j++) begin
      step[j] = div_step(rem_q[j-1], den_q[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    rem_q[0]  <= $unsigned(num);
    den_q[0]  <= $unsigned(den);
    q_q[0]    <= '0;
    zero_q[0] <= !(num_pos && den_pos);
    one_q[0]  <= num >= den;
    for (int j = 1; j <= QB; j++) begin
      rem_q[j]  <= step[j][W-1:0];
      den_q[j]  <= den_q[j-1];
      q_q[j]    <= {q_q[j-1][QB-2:0], step[j][W]};
      zero_q[j] <= zero_q[j-1];
      one_q[j]  <= one_q[j-1];
    end
    if (zero_q[QB]) begin
      quo <= '0;
    end else if (one_q[QB]) begin
      quo <= {1'b1, {QB{1'b0}}};
    end else begin
      quo <= {1'b0, q_q[QB]};
    end
  end

endmodule
`default_nettype wire

@@ src/spd_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spd_dist (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  spd_pkg::geo_t    geo,
  input  spd_pkg::param_t  s,
  input  spd_pkg::param_t  t,
  input  logic             par,
  output logic             result_valid,
  output spd_pkg::result_t result
);

  localparam int CB     = spd_pkg::COORD_BITS;
  localparam int PF     = spd_pkg::PARAM_FRAC_BITS;
  localparam int WS_W   = CB + 1 + PF;
  localparam int MUL_W  = CB + PF + 2;
  localparam int DIFF_W = MUL_W + 2;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int HI_W   = SUM_W - 2 * PF;
  localparam int DB     = spd_pkg::DIST_BITS;

  logic [4:0]                vld;
  spd_pkg::param_t           s_d   [4];
  spd_pkg::param_t           t_d   [4];
  logic                      par_d [4];
  logic signed [WS_W-1:0]    ws    [3];
  logic signed [MUL_W-1:0]   us    [3];
  logic signed [MUL_W-1:0]   vt    [3];
  logic signed [DIFF_W-1:0]  diff  [3];
  logic signed [SQ_W-1:0]    sq    [3];
  logic [SUM_W-1:0]          sum;
  logic [HI_W-1:0]           hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s_d[0]   <= s;
    t_d[0]   <= t;
    par_d[0] <= par;
    for (int k = 1; k < 4; k++) begin
      s_d[k]   <= s_d[k-1];
      t_d[k]   <= t_d[k-1];
      par_d[k] <= par_d[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      ws[i]   <= $signed({geo.w[i], {PF{1'b0}}});
      us[i]   <= $signed(geo.u[i]) * $signed({1'b0, s});
      vt[i]   <= $signed(geo.v[i]) * $signed({1'b0, t});
      diff[i] <= $signed({{(DIFF_W-WS_W){ws[i][WS_W-1]}}, ws[i]})
               + $signed({{(DIFF_W-MUL_W){us[i][MUL_W-1]}}, us[i]})
               - $signed({{(DIFF_W-MUL_W){vt[i][MUL_W-1]}}, vt[i]});
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    spd_wmul #(.W(DIFF_W)) u_sq (
      .clk (clk),
      .a   (diff[i]),
      .b   (diff[i]),
      .p   (sq[i])
    );
  end

  always_comb begin
    sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    hi  = sum[SUM_W-1:2*PF];
  end

  always_ff @(posedge clk) begin
    result.distance_squared <= ((hi >> DB) != '0) ? '1 : hi[DB-1:0];
    result.first_param      <= s_d[3];
    result.second_param     <= t_d[3];
    result.parallel_flag    <= par_d[3];
  end

  assign result_valid = vld[4];

endmodule
`default_nettype wire

@@ src/segment_pair_distance_sq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Squared distance between two 3D segments, fully pipelined: one pair is
// taken in every cycle (busy stays low) and its result is strobed on
// result_valid for a single cycle. The receiver cannot stall the block, so
// results must be captured when strobed. Each segment parameter is formed
// by a 16-stage restoring divider, with split wide multipliers ahead of
// and behind it. Write thresh_wdata with thresh_we only while no pair is
// in flight.
module segment_pair_distance_sq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  spd_pkg::pair_t                      item,
  input  logic                                thresh_we,
  input  logic [spd_pkg::THRESH_BITS-1:0]     thresh_wdata,
  output logic                                result_valid,
  output spd_pkg::result_t                    result
);

  localparam int CB      = spd_pkg::COORD_BITS;
  localparam int OB      = spd_pkg::OFS_BITS;
  localparam int DB      = spd_pkg::DOT_BITS;
  localparam int WB      = spd_pkg::WIDE_BITS;
  localparam int TB      = spd_pkg::THRESH_BITS;
  localparam int DL      = spd_pkg::DIV_LAT;
  localparam int GEO_LEN = 7 + DL;

  logic [TB-1:0]           thresh;
  logic [GEO_LEN-1:0]      vld;
  spd_pkg::geo_t           geo_in;
  spd_pkg::geo_t           geo_pipe [GEO_LEN];
  logic                    par_pipe [DL+1];
  logic signed [2*CB-1:0]  puu [3];
  logic signed [2*CB-1:0]  puv [3];
  logic signed [2*CB-1:0]  pvv [3];
  logic signed [2*CB:0]    puw [3];
  logic signed [2*CB:0]    pvw [3];
  spd_pkg::dot_t           dot_a, dot_b, dot_c, dot_d, dot_e;
  spd_pkg::dot_t           sum_a, sum_b, sum_c, sum_d, sum_e;
  spd_pkg::dot_t           b_pipe [3];
  spd_pkg::dot_t           c_pipe [3];
  spd_pkg::dot_t           d_pipe [3];
  spd_pkg::dot_t           e_pipe [3];
  logic signed [2*DB-1:0]  p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
  spd_pkg::wide_t          det, num_s_raw, num_t_raw;
  spd_pkg::wide_t          num_s, den_s, num_t, den_t;
  logic                    par_c;
  logic                    b_gt_c;
  spd_pkg::param_t         s_par, t_par;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= spd_pkg::THRESH_RESET;
    end else if (thresh_we) begin
      thresh <= thresh_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[GEO_LEN-2:0], start && !busy};
    end
  end

  always_comb begin
    geo_in.u[0] = item.first_dir_x;
    geo_in.u[1] = item.first_dir_y;
    geo_in.u[2] = item.first_dir_z;
    geo_in.v[0] = item.second_dir_x;
    geo_in.v[1] = item.second_dir_y;
    geo_in.v[2] = item.second_dir_z;
    geo_in.w[0] = $signed({item.first_origin_x[CB-1], item.first_origin_x})
                - $signed({item.second_origin_x[CB-1], item.second_origin_x});
    geo_in.w[1] = $signed({item.first_origin_y[CB-1], item.first_origin_y})
                - $signed({item.second_origin_y[CB-1], item.second_origin_y});
    geo_in.w[2] = $signed({item.first_origin_z[CB-1], item.first_origin_z})
                - $signed({item.second_origin_z[CB-1], item.second_origin_z});
  end

  always_ff @(posedge clk) begin
    geo_pipe[0] <= geo_in;
    for (int k = 1; k < GEO_LEN; k++) begin
      geo_pipe[k] <= geo_pipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      puu[i] <= $signed(geo_pipe[0].u[i]) * $signed(geo_pipe[0].u[i]);
      puv[i] <= $signed(geo_pipe[0].u[i]) * $signed(geo_pipe[0].v[i]);
      pvv[i] <= $signed(geo_pipe[0].v[i]) * $signed(geo_pipe[0].v[i]);
      puw[i] <= $signed(geo_pipe[0].u[i]) * $signed(geo_pipe[0].w[i]);
      pvw[i] <= $signed(geo_pipe[0].v[i]) * $signed(geo_pipe[0].w[i]);
    end
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    sum_c = '0;
    sum_d = '0;
    sum_e = '0;
    for (int i = 0; i < 3; i++) begin
      sum_a = sum_a + $signed({{(DB-2*CB){puu[i][2*CB-1]}}, puu[i]});
      sum_b = sum_b + $signed({{(DB-2*CB){puv[i][2*CB-1]}}, puv[i]});
      sum_c = sum_c + $signed({{(DB-2*CB){pvv[i][2*CB-1]}}, pvv[i]});
      sum_d = sum_d + $signed({{(DB-2*CB-1){puw[i][2*CB]}}, puw[i]});
      sum_e = sum_e + $signed({{(DB-2*CB-1){pvw[i][2*CB]}}, pvw[i]});
    end
  end

  always_ff @(posedge clk) begin
    dot_a <= sum_a;
    dot_b <= sum_b;
    dot_c <= sum_c;
    dot_d <= sum_d;
    dot_e <= sum_e;
    b_pipe[0] <= dot_b;
    c_pipe[0] <= dot_c;
    d_pipe[0] <= dot_d;
    e_pipe[0] <= dot_e;
    for (int k = 1; k < 3; k++) begin
      b_pipe[k] <= b_pipe[k-1];
      c_pipe[k] <= c_pipe[k-1];
      d_pipe[k] <= d_pipe[k-1];
      e_pipe[k] <= e_pipe[k-1];
    end
  end

  spd_wmul #(.W(DB)) u_mul_ac (.clk(clk), .a(dot_a), .b(dot_c), .p(p_ac));
  spd_wmul #(.W(DB)) u_mul_bb (.clk(clk), .a(dot_b), .b(dot_b), .p(p_bb));
  spd_wmul #(.W(DB)) u_mul_be (.clk(clk), .a(dot_b), .b(dot_e), .p(p_be));
  spd_wmul #(.W(DB)) u_mul_cd (.clk(clk), .a(dot_c), .b(dot_d), .p(p_cd));
  spd_wmul #(.W(DB)) u_mul_ae (.clk(clk), .a(dot_a), .b(dot_e), .p(p_ae));
  spd_wmul #(.W(DB)) u_mul_bd (.clk(clk), .a(dot_b), .b(dot_d), .p(p_bd));

  always_ff @(posedge clk) begin
    det       <= $signed({p_ac[2*DB-1], p_ac}) - $signed({p_bb[2*DB-1], p_bb});
    num_s_raw <= $signed({p_be[2*DB-1], p_be}) - $signed({p_cd[2*DB-1], p_cd});
    num_t_raw <= $signed({p_ae[2*DB-1], p_ae}) - $signed({p_bd[2*DB-1], p_bd});
  end

  always_comb begin
    par_c  = det < $signed({{(WB-TB){1'b0}}, thresh});
    b_gt_c = b_pipe[2] > c_pipe[2];
  end

  always_ff @(posedge clk) begin
    par_pipe[0] <= par_c;
    for (int k = 1; k <= DL; k++) begin
      par_pipe[k] <= par_pipe[k-1];
    end
    num_s <= par_c ? '0 : num_s_raw;
    den_s <= det;
    if (!par_c) begin
      num_t <= num_t_raw;
      den_t <= det;
    end else if (b_gt_c) begin
      num_t <= $signed({{(WB-DB){d_pipe[2][DB-1]}}, d_pipe[2]});
      den_t <= $signed({{(WB-DB){b_pipe[2][DB-1]}}, b_pipe[2]});
    end else begin
      num_t <= $signed({{(WB-DB){e_pipe[2][DB-1]}}, e_pipe[2]});
      den_t <= $signed({{(WB-DB){c_pipe[2][DB-1]}}, c_pipe[2]});
    end
  end

  spd_div #(.W(WB), .QB(spd_pkg::PARAM_FRAC_BITS)) u_div_s (
    .clk (clk),
    .num (num_s),
    .den (den_s),
    .quo (s_par)
  );

  spd_div #(.W(WB), .QB(spd_pkg::PARAM_FRAC_BITS)) u_div_t (
    .clk (clk),
    .num (num_t),
    .den (den_t),
    .quo (t_par)
  );

  spd_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (vld[GEO_LEN-1]),
    .geo          (geo_pipe[GEO_LEN-1]),
    .s            (s_par),
    .t            (t_par),
    .par          (par_pipe[DL]),
    .result_valid (result_valid),
    .result       (result)
  );

  a_sq_lengths_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (!dot_a[DB-1] && !dot_c[DB-1]))
    else $error("negative squared length");

  a_det_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> !det[WB-1])
    else $error("negative determinant");

  a_param_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.first_param <= spd_pkg::PARAM_ONE &&
                      result.second_param <= spd_pkg::PARAM_ONE))
    else $error("segment parameter above one");

  a_parallel_first_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.parallel_flag) |-> (result.first_param == '0))
    else $error("parallel transfer with nonzero first parameter");

endmodule
`default_nettype wire

@@ tb/sv/segment_pair_distance_sq_tb.sv @@
`timescale 1ns / 1ps
module segment_pair_distance_sq_tb;

  typedef logic signed [191:0] big_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TH_BITS        = spd_pkg::THRESH_BITS;
  localparam int PF_BITS        = spd_pkg::PARAM_FRAC_BITS;
  localparam int D_BITS         = spd_pkg::DIST_BITS;
  localparam logic [TH_BITS-1:0] THRESH_MAX = {TH_BITS{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  spd_pkg::pair_t item = '0;
  logic thresh_we = 1'b0;
  logic [TH_BITS-1:0] thresh_wdata = '0;
  logic result_valid;
  spd_pkg::result_t result;

  segment_pair_distance_sq u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .thresh_we(thresh_we), .thresh_wdata(thresh_wdata),
    .result_valid(result_valid), .result(result)
  );

  spd_pkg::pair_t pending_pairs[$];
  spd_pkg::result_t expected_results[$];
  logic [TH_BITS-1:0] model_thresh = spd_pkg::THRESH_RESET;
  int mismatches = 0;
  int gap_left = 0;
  bit quiet = 1'b0;
  int stall_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic spd_pkg::param_t clamp_ratio(big_t num, big_t den);
    big_t q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return spd_pkg::PARAM_ONE;
    q = (num <<< PF_BITS) / den;
    return q[spd_pkg::PARAM_BITS-1:0];
  endfunction

  function automatic spd_pkg::result_t segment_distance(spd_pkg::pair_t p,
                                                        logic [TH_BITS-1:0] th);
    big_t u[3], v[3], w[3];
    big_t a, b, c, d, e, det, sum, diff, thb, sb, tb;
    spd_pkg::result_t r;
    u[0] = p.first_dir_x;  u[1] = p.first_dir_y;  u[2] = p.first_dir_z;
    v[0] = p.second_dir_x; v[1] = p.second_dir_y; v[2] = p.second_dir_z;
    w[0] = p.first_origin_x; w[0] = w[0] - big_t'(p.second_origin_x);
    w[1] = p.first_origin_y; w[1] = w[1] - big_t'(p.second_origin_y);
    w[2] = p.first_origin_z; w[2] = w[2] - big_t'(p.second_origin_z);
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    det = a*c - b*b;
    thb = {152'd0, th};
    r.parallel_flag = det < thb;
    if (r.parallel_flag) begin
      r.first_param = '0;
      r.second_param = (b > c) ? clamp_ratio(d, b) : clamp_ratio(e, c);
    end else begin
      r.first_param = clamp_ratio(b*e - c*d, det);
      r.second_param = clamp_ratio(a*e - b*d, det);
    end
    sb = {175'd0, r.first_param};
    tb = {175'd0, r.second_param};
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      diff = (w[i] <<< PF_BITS) + u[i]*sb - v[i]*tb;
      sum = sum + diff*diff;
    end
    sum = sum >>> (2*PF_BITS);
    if (sum > big_t'({D_BITS{1'b1}})) r.distance_squared = {D_BITS{1'b1}};
    else r.distance_squared = sum[D_BITS-1:0];
    return r;
  endfunction

  function automatic spd_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return spd_pkg::coord_t'($urandom);
      1: return spd_pkg::coord_t'(int'($urandom_range(0, 32767)) - 16384);
      2: return spd_pkg::coord_t'(int'($urandom_range(0, 32)) - 16);
      default: return spd_pkg::coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic spd_pkg::pair_t make_pair(int shape, int mode);
    spd_pkg::pair_t p;
    int k;
    p.first_origin_x = rand_coord(mode);  p.first_origin_y = rand_coord(mode);
    p.first_origin_z = rand_coord(mode);  p.first_dir_x = rand_coord(mode);
    p.first_dir_y = rand_coord(mode);     p.first_dir_z = rand_coord(mode);
    p.second_origin_x = rand_coord(mode); p.second_origin_y = rand_coord(mode);
    p.second_origin_z = rand_coord(mode); p.second_dir_x = rand_coord(mode);
    p.second_dir_y = rand_coord(mode);    p.second_dir_z = rand_coord(mode);
    k = int'($urandom_range(0, 4)) - 2;
    case (shape)
      1: begin
        p.second_dir_x = spd_pkg::coord_t'(k * p.first_dir_x);
        p.second_dir_y = spd_pkg::coord_t'(k * p.first_dir_y);
        p.second_dir_z = spd_pkg::coord_t'(k * p.first_dir_z);
      end
      2: begin
        p.first_dir_x = '0; p.first_dir_y = '0; p.first_dir_z = '0;
      end
      3: begin
        p.second_dir_x = '0; p.second_dir_y = '0; p.second_dir_z = '0;
      end
      4: begin
        p.second_dir_x = spd_pkg::coord_t'(p.first_dir_x + rand_coord(2));
        p.second_dir_y = spd_pkg::coord_t'(p.first_dir_y + rand_coord(2));
        p.second_dir_z = spd_pkg::coord_t'(p.first_dir_z + rand_coord(2));
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic spd_pkg::pair_t uniform_pair(spd_pkg::coord_t val);
    spd_pkg::pair_t p;
    p = {12{val}};
    return p;
  endfunction

  task automatic queue_random(int count);
    int shape, mode;
    for (int n = 0; n < count; n++) begin
      shape = ($urandom_range(0, 9) < 6) ? 0 : int'($urandom_range(1, 4));
      mode = int'($urandom_range(0, 3));
      pending_pairs.push_back(make_pair(shape, mode));
    end
  endtask

  task automatic drain_and_write(logic [TH_BITS-1:0] value);
    wait (pending_pairs.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    thresh_we <= 1'b1;
    thresh_wdata <= value;
    @(posedge clk);
    model_thresh = value;
    thresh_we <= 1'b0;
  endtask

  // driver: advance the pending queue on each transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(segment_distance(item, model_thresh));
        void'(pending_pairs.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        gap_left <= $urandom_range(0, 17);
        start <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        start <= 1'b1;
        item <= pending_pairs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        spd_pkg::result_t exp_r;
        exp_r = expected_results.pop_front();
        if (exp_r.distance_squared !== result.distance_squared ||
            exp_r.first_param !== result.first_param ||
            exp_r.second_param !== result.second_param ||
            exp_r.parallel_flag !== result.parallel_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, result);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** segment_pair_distance_sq: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    spd_pkg::pair_t p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    pending_pairs.push_back(uniform_pair(spd_pkg::coord_t'(0)));
    pending_pairs.push_back(uniform_pair(spd_pkg::coord_t'(24'h7FFFFF)));
    pending_pairs.push_back(uniform_pair(spd_pkg::coord_t'(24'h800000)));
    pending_pairs.push_back(uniform_pair(spd_pkg::coord_t'(24'hFFFFFF)));
    p = '0;
    p.first_origin_x = 24'h800000; p.first_dir_x = 24'h7FFFFF;
    p.second_origin_x = 24'h7FFFFF; p.second_dir_y = 24'h800000;
    pending_pairs.push_back(p);
    p = '0;
    p.first_dir_x = 24'h1000; p.second_origin_y = 24'h800;
    p.second_origin_x = 24'h800; p.second_dir_y = 24'hFFF000;
    pending_pairs.push_back(p);
    p.second_origin_z = 24'h3000;
    pending_pairs.push_back(p);
    for (int s = 1; s <= 4; s++) begin
      pending_pairs.push_back(make_pair(s, 1));
      pending_pairs.push_back(make_pair(s, 0));
      pending_pairs.push_back(make_pair(s, 2));
    end
    pending_pairs.push_back(make_pair(0, 1));
    pending_pairs.push_back(make_pair(0, 3));
    queue_random(350);
    drain_and_write('0);
    pending_pairs.push_back(uniform_pair(spd_pkg::coord_t'(0)));
    pending_pairs.push_back(make_pair(1, 1));
    pending_pairs.push_back(make_pair(2, 1));
    queue_random(320);
    drain_and_write(THRESH_MAX);
    queue_random(300);
    drain_and_write(TH_BITS'({$urandom, $urandom}));
    queue_random(300);
    drain_and_write(spd_pkg::THRESH_RESET);
    quiet = 1'b1;
    queue_random(300);
    wait (pending_pairs.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** segment_pair_distance_sq: PASSED **");
    end else begin
      $display("** segment_pair_distance_sq: FAILED **");
    end
    $finish;
  end

endmodule
